// ===== hw/rtl/gsp_pkg.sv =====
package gsp_pkg;

  localparam int BUTTON_W     = 16;
  localparam int TICK_W       = 16;
  localparam int FIRST_W      = 4;
  localparam int SCAN_BUTTONS = 12;
  localparam int START_BUTTON = 3;
  localparam int NUM_BITS_DEF = 16;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [TICK_W-1:0] LATCH_TICKS_RST = TICK_W'(12);
  localparam logic [TICK_W-1:0] HALF_PERIOD_RST = TICK_W'(6);

  // register index, taken from paddr[2]
  localparam logic REG_LATCH_TICKS = 1'b0;
  localparam logic REG_HALF_PERIOD = 1'b1;

  typedef struct packed {
    logic                clock_pin;
    logic                latch_pin;
    logic                read_done;
    logic [BUTTON_W-1:0] button_bits;
  } seq_res_t;

endpackage

// ===== hw/rtl/gsp_seq.sv =====
module gsp_seq #(
  parameter int NUM_BITS = gsp_pkg::NUM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        data_pin,
  input  logic                        start_read,
  input  logic [gsp_pkg::TICK_W-1:0]  latch_ticks,
  input  logic [gsp_pkg::TICK_W-1:0]  half_period_ticks,
  output gsp_pkg::seq_res_t           res
);

  localparam int IDX_W = $clog2(NUM_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BITS - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LATCH,
    PH_HIGH,
    PH_LOW
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [gsp_pkg::TICK_W-1:0]      tick_count_r, tick_count_nxt;
  logic [IDX_W-1:0]                bit_index_r, bit_index_nxt;
  logic [gsp_pkg::BUTTON_W-1:0]    shift_bits_r, shift_bits_nxt;
  logic [gsp_pkg::BUTTON_W-1:0]    last_bits_r, last_bits_nxt;
  logic                            clock_r, clock_nxt;
  logic                            latch_r, latch_nxt;
  logic                            done_nxt;

  logic [gsp_pkg::TICK_W-1:0]      tick_inc;
  logic [gsp_pkg::TICK_W-1:0]      target;
  logic                            wait_over;
  logic [gsp_pkg::BUTTON_W-1:0]    sampled;

  // saturating tick count, a zero target ends the wait at once
  assign tick_inc  = (tick_count_r == '1) ? tick_count_r : tick_count_r + 1'b1;
  assign target    = (phase_r == PH_LATCH) ? latch_ticks : half_period_ticks;
  assign wait_over = (tick_inc >= target);

  // only the first sixteen samples are kept
  always_comb begin
    sampled = shift_bits_r;
    for (int i = 0; i < gsp_pkg::BUTTON_W; i++) begin
      if (int'(bit_index_r) == i) begin
        sampled[i] = data_pin;
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    bit_index_nxt  = bit_index_r;
    shift_bits_nxt = shift_bits_r;
    last_bits_nxt  = last_bits_r;
    clock_nxt      = clock_r;
    latch_nxt      = latch_r;
    done_nxt       = 1'b0;
    unique case (phase_r)
      PH_LATCH: begin
        tick_count_nxt = wait_over ? '0 : tick_inc;
        if (wait_over) begin
          latch_nxt = 1'b0;
          phase_nxt = PH_HIGH;
        end
      end
      PH_HIGH: begin
        tick_count_nxt = wait_over ? '0 : tick_inc;
        if (wait_over) begin
          clock_nxt = 1'b0;
          phase_nxt = PH_LOW;
        end
      end
      PH_LOW: begin
        tick_count_nxt = wait_over ? '0 : tick_inc;
        if (wait_over) begin
          shift_bits_nxt = sampled;
          clock_nxt      = 1'b1;
          if (bit_index_r == LAST_IDX) begin
            last_bits_nxt = sampled;
            done_nxt      = 1'b1;
            bit_index_nxt = '0;
            phase_nxt     = PH_IDLE;
          end else begin
            bit_index_nxt = bit_index_r + 1'b1;
            phase_nxt     = PH_HIGH;
          end
        end
      end
      PH_IDLE: begin
        if (start_read) begin
          clock_nxt      = 1'b1;
          latch_nxt      = 1'b1;
          tick_count_nxt = '0;
          bit_index_nxt  = '0;
          shift_bits_nxt = '1;
          phase_nxt      = PH_LATCH;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      bit_index_r  <= '0;
      shift_bits_r <= '1;
      last_bits_r  <= '1;
      clock_r      <= 1'b1;
      latch_r      <= 1'b0;
    end else if (en) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_bits_r <= shift_bits_nxt;
      last_bits_r  <= last_bits_nxt;
      clock_r      <= clock_nxt;
      latch_r      <= latch_nxt;
    end
  end

  assign res.clock_pin   = clock_nxt;
  assign res.latch_pin   = latch_nxt;
  assign res.read_done   = done_nxt;
  assign res.button_bits = last_bits_nxt;

`ifndef SYNTHESIS
  a_latch_in_latch_phase: assert property (@(posedge clk) disable iff (!rst_n)
    latch_r |-> phase_r == PH_LATCH)
    else $error("latch high outside latch phase");

  a_clock_low_in_low_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !clock_r |-> phase_r == PH_LOW)
    else $error("clock low outside low phase");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> bit_index_r == '0 && tick_count_r == '0)
    else $error("counters not clear in idle");

  a_start_enters_latch: assert property (@(posedge clk) disable iff (!rst_n)
    en && phase_r == PH_IDLE && start_read |=> phase_r == PH_LATCH && shift_bits_r == '1)
    else $error("start did not begin a read");
`endif

endmodule

// ===== hw/rtl/gsp_decode.sv =====
module gsp_decode (
  input  logic [gsp_pkg::BUTTON_W-1:0] button_bits,
  output logic [gsp_pkg::FIRST_W-1:0]  first_pressed,
  output logic                         quit_request
);

  // lowest active-low button among the scanned ones
  always_comb begin
    first_pressed = gsp_pkg::FIRST_W'(gsp_pkg::SCAN_BUTTONS);
    for (int i = gsp_pkg::SCAN_BUTTONS - 1; i >= 0; i--) begin
      if (!button_bits[i]) begin
        first_pressed = gsp_pkg::FIRST_W'(i);
      end
    end
  end

  assign quit_request = (first_pressed == gsp_pkg::FIRST_W'(gsp_pkg::START_BUTTON));

endmodule

// ===== hw/rtl/gamepad_serial_poller.sv =====
// channel  direction  signals
// in       input      in_valid, in_ready, in_data_pin, in_start_read (one word per tick)
// out      output     out_valid, out_ready, out_clock_pin .. out_quit_request
// cfg      apb        psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// one word per cycle while out is not stalled: each tick updates the sequencer and its
// result is loaded into the output register on the same tick.
// in_ready is high while the output register is empty or being taken this cycle.
// synchronous active-low reset; no clearing pass, ready right after reset.
// a stall on out holds the result and stops the tick sequencer with it.
module gamepad_serial_poller #(
  parameter int NUM_BITS = gsp_pkg::NUM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_data_pin,
  input  logic                            in_start_read,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_clock_pin,
  output logic                            out_latch_pin,
  output logic                            out_read_done,
  output logic [gsp_pkg::BUTTON_W-1:0]    out_button_bits,
  output logic [gsp_pkg::FIRST_W-1:0]     out_first_pressed,
  output logic                            out_quit_request,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gsp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [gsp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [gsp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [gsp_pkg::TICK_W-1:0]   latch_ticks_r;
  logic [gsp_pkg::TICK_W-1:0]   half_period_r;
  logic                         accept;
  logic                         cfg_wr;
  gsp_pkg::seq_res_t            res;
  logic [gsp_pkg::FIRST_W-1:0]  first_pressed;
  logic                         quit_request;
  logic                         out_valid_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_ticks_r <= gsp_pkg::LATCH_TICKS_RST;
      half_period_r <= gsp_pkg::HALF_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        gsp_pkg::REG_LATCH_TICKS: latch_ticks_r <= pwdata[gsp_pkg::TICK_W-1:0];
        gsp_pkg::REG_HALF_PERIOD: half_period_r <= pwdata[gsp_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gsp_pkg::REG_LATCH_TICKS:
        prdata = gsp_pkg::CFG_DATA_W'(latch_ticks_r);
      gsp_pkg::REG_HALF_PERIOD:
        prdata = gsp_pkg::CFG_DATA_W'(half_period_r);
      default: prdata = '0;
    endcase
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  gsp_seq #(
    .NUM_BITS (NUM_BITS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (accept),
    .data_pin          (in_data_pin),
    .start_read        (in_start_read),
    .latch_ticks       (latch_ticks_r),
    .half_period_ticks (half_period_r),
    .res               (res)
  );

  gsp_decode u_decode (
    .button_bits   (res.button_bits),
    .first_pressed (first_pressed),
    .quit_request  (quit_request)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word, loaded with each tick
  always_ff @(posedge clk) begin
    if (accept) begin
      out_clock_pin     <= res.clock_pin;
      out_latch_pin     <= res.latch_pin;
      out_read_done     <= res.read_done;
      out_button_bits   <= res.button_bits;
      out_first_pressed <= first_pressed;
      out_quit_request  <= quit_request;
    end
  end

  assign out_valid = out_valid_r;

endmodule
